// File: rtl/tdss_pkg.sv
// Package: shared types, constants and segment tables for the three-digit serializer.
`timescale 1ns / 1ps

package tdss_pkg;

    // Segment word and serial framing
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned HALF_BITS  = 16;
    localparam int unsigned CNT_BITS   = 6;
    localparam logic [CNT_BITS-1:0] LATCH_CNT = 6'd32;

    // Reciprocal for an exact divide by ten of any 16-bit value
    localparam int unsigned DIV10_BITS  = 17;
    localparam logic [DIV10_BITS-1:0] DIV10_MUL = 17'd52429;
    localparam int unsigned DIV10_SHIFT = 19;
    localparam int unsigned PROD_BITS   = HALF_BITS + DIV10_BITS;

    // Input function codes
    localparam logic FUNC_DECIMAL = 1'b0;
    localparam logic FUNC_RAW     = 1'b1;

    // Write side of the word queue
    typedef struct packed {
        logic                 push;
        logic [WORD_BITS-1:0] word;
    } q_wr_t;

    // Read side of the word queue
    typedef struct packed {
        logic                 not_empty;
        logic [WORD_BITS-1:0] word;
    } q_rd_t;

    // Outer displays (1 and 3): PCDE--------GFAB
    function automatic logic [HALF_BITS-1:0] outer_seg(input logic [3:0] digit);
        logic [HALF_BITS-1:0] seg;
        case (digit)
            4'd0:    seg = 16'h7007;
            4'd1:    seg = 16'h4001;
            4'd2:    seg = 16'h300B;
            4'd3:    seg = 16'h600B;
            4'd4:    seg = 16'h400D;
            4'd5:    seg = 16'h600E;
            4'd6:    seg = 16'h700E;
            4'd7:    seg = 16'h4003;
            4'd8:    seg = 16'h700F;
            4'd9:    seg = 16'h600F;
            default: seg = '0;
        endcase
        return seg;
    endfunction

    // Middle display (2): ----PCDEGFAB----
    function automatic logic [HALF_BITS-1:0] middle_seg(input logic [3:0] digit);
        logic [HALF_BITS-1:0] seg;
        case (digit)
            4'd0:    seg = 16'h0770;
            4'd1:    seg = 16'h0410;
            4'd2:    seg = 16'h03B0;
            4'd3:    seg = 16'h06B0;
            4'd4:    seg = 16'h04D0;
            4'd5:    seg = 16'h06E0;
            4'd6:    seg = 16'h07E0;
            4'd7:    seg = 16'h0430;
            4'd8:    seg = 16'h07F0;
            4'd9:    seg = 16'h06F0;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

// File: rtl/tdss_front.sv
// Front end: accepts items and builds the 32-bit segment word, one digit per cycle.
`timescale 1ns / 1ps

module tdss_front
    import tdss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_BITS-1:0] s_tdata,
    input  logic                 s_tuser,
    output q_wr_t                q_wr,
    input  logic                 q_full
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_UNITS = 5'b00010,
        ST_TENS  = 5'b00100,
        ST_HUND  = 5'b01000,
        ST_PUSH  = 5'b10000
    } front_state_t;

    front_state_t          state_reg, state_next;
    logic [HALF_BITS-1:0]  num_reg, num_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;

    logic                  accept;
    logic                  push;
    logic [PROD_BITS-1:0]  prod;
    logic [HALF_BITS-1:0]  quot;
    logic [HALF_BITS-1:0]  quot_x10;
    logic [HALF_BITS-1:0]  diff;
    logic [3:0]            digit;
    logic [WORD_BITS-1:0]  seg;

    // Divide by ten through the reciprocal; remainder is the current digit
    assign prod     = PROD_BITS'(num_reg) * PROD_BITS'(DIV10_MUL);
    assign quot     = HALF_BITS'(prod >> DIV10_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign diff     = num_reg - quot_x10;
    assign digit    = diff[3:0];

    // Pattern of the digit for the display in turn
    always_comb
    begin
        case (state_reg)
            ST_UNITS: seg = {{HALF_BITS{1'b0}}, outer_seg(digit)};
            ST_TENS:  seg = {{HALF_BITS{1'b0}}, middle_seg(digit)};
            ST_HUND:  seg = {outer_seg(digit), {HALF_BITS{1'b0}}};
            default:  seg = '0;
        endcase
    end

    // Handshakes: a new item may enter in the cycle the finished word leaves
    assign push     = (state_reg == ST_PUSH) && !q_full;
    assign s_tready = (state_reg == ST_IDLE) || push;
    assign accept   = s_tvalid && s_tready;

    assign q_wr.push = push;
    assign q_wr.word = word_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        word_next  = word_reg;
        if (accept)
        begin
            num_next = s_tdata[HALF_BITS-1:0];
            if (s_tuser == FUNC_RAW)
            begin
                word_next  = s_tdata;
                state_next = ST_PUSH;
            end
            else
            begin
                word_next  = '0;
                state_next = ST_UNITS;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    state_next = ST_IDLE;
                end
                ST_UNITS:
                begin
                    num_next   = quot;
                    word_next  = word_reg | seg;
                    state_next = ST_TENS;
                end
                ST_TENS:
                begin
                    num_next   = quot;
                    word_next  = word_reg | seg;
                    state_next = ST_HUND;
                end
                ST_HUND:
                begin
                    num_next   = quot;
                    word_next  = word_reg | seg;
                    state_next = ST_PUSH;
                end
                ST_PUSH:
                begin
                    if (push)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        word_reg <= word_next;
    end

endmodule

// File: rtl/tdss_queue.sv
// Two-entry word queue between the front end and the shifter.
`timescale 1ns / 1ps

module tdss_queue
    import tdss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t q_wr,
    output logic  q_full,
    output q_rd_t q_rd,
    input  logic  q_pop
);

    localparam logic [1:0] DEPTH = 2'd2;

    logic [WORD_BITS-1:0] mem_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_full         = (count_reg == DEPTH);
    assign q_rd.not_empty = (count_reg != 2'd0);
    assign q_rd.word      = mem_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !q_full;
    assign do_pop  = q_pop && q_rd.not_empty;

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.word;
        end
    end

    // Checks
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_full)
        else $error("word pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_rd.not_empty)
        else $error("word popped from an empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH)
        else $error("queue fill count out of range");

endmodule

// File: rtl/tdss_back.sv
// Back end: shifts each word out LSB first, then issues the latch strobe.
`timescale 1ns / 1ps

module tdss_back
    import tdss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_rd_t      q_rd,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    logic                 active_reg, active_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] sh_reg, sh_next;
    logic                 valid_reg, valid_next;
    logic                 bit_reg, bit_next;
    logic                 latch_reg, latch_next;
    logic                 out_free;

    assign out_free = !valid_reg || m_tready;

    // Result selection: next bit, latch strobe, or the head of a new word
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        sh_next     = sh_reg;
        valid_next  = valid_reg;
        bit_next    = bit_reg;
        latch_next  = latch_reg;
        q_pop       = 1'b0;
        if (out_free)
        begin
            if (active_reg)
            begin
                valid_next = 1'b1;
                if (cnt_reg == LATCH_CNT)
                begin
                    bit_next    = 1'b0;
                    latch_next  = 1'b1;
                    active_next = 1'b0;
                end
                else
                begin
                    bit_next   = sh_reg[0];
                    latch_next = 1'b0;
                    sh_next    = sh_reg >> 1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            else if (q_rd.not_empty)
            begin
                q_pop       = 1'b1;
                valid_next  = 1'b1;
                bit_next    = q_rd.word[0];
                latch_next  = 1'b0;
                sh_next     = q_rd.word >> 1;
                cnt_next    = CNT_BITS'(1);
                active_next = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        bit_reg   <= bit_next;
        latch_reg <= latch_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, bit_reg};
    assign m_tuser  = latch_reg;
    assign m_tlast  = latch_reg;

    // Checks
    a_latch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && latch_reg) |-> !bit_reg)
        else $error("data bit set on latch strobe");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cnt_reg <= LATCH_CNT) && (cnt_reg != '0))
        else $error("bit counter out of range");

    a_latch_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_free && active_reg && cnt_reg == LATCH_CNT) |=> (latch_reg && !active_reg))
        else $error("latch strobe not issued after the 32nd bit");

endmodule

// File: rtl/three_digit_segment_serializer.sv
// Top level: three-digit seven-segment serializer.
//
//  channel   dir  payload                               handshake
//  s_axis    in   tdata[31:0] data_word, tuser func     tvalid/tready
//  m_axis    out  tdata[0] serial_bit, tuser latch,     tvalid/tready
//                 tlast last_of_run
//
// Each item gives 33 output transfers: 32 data bits, LSB first, then the latch strobe.
// Sustained rate is set by the shifter, one result per cycle unless m_axis stalls.
// Raw words go straight to push; decimal words first build units, tens, hundreds.
// A two-entry queue lets the front end take the next item while the shifter stalls.
// Reset is asynchronous, active low; it empties the queue and clears m_axis_tvalid.
`timescale 1ns / 1ps

module three_digit_segment_serializer
    import tdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] serial_bit, [7:1] zero
    output logic        m_axis_tuser,   // [0] latch_pulse
    output logic        m_axis_tlast
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    // Word builder
    tdss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_wr     (q_wr),
        .q_full   (q_full)
    );

    // Decoupling queue
    tdss_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .q_pop  (q_pop)
    );

    // Serial shifter
    tdss_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_rd     (q_rd),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule
